/* hdl/apd_pkg.sv */
// Shared types, constants and helpers for the accelerator pool dispatcher.
`timescale 1ns / 1ps
package apd_pkg;

  localparam int NUM_ACCELS = 16;
  localparam int NUM_GROUPS = 4;
  localparam int QDEPTH     = 16;

  localparam int ACCEL_W    = 4;
  localparam int GROUP_W    = 2;
  localparam int SLOT_W     = 4;
  localparam int PTR_W      = 4;
  localparam int CNT_W      = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GROUP0       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GROUP1       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GROUP2       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GROUP3       = 3'd4;

  localparam logic [CNT_W-1:0] SLOTS_RESET = 5'd16;
  localparam logic [NUM_ACCELS-1:0] GROUP0_RESET = 16'h000F;
  localparam logic [NUM_ACCELS-1:0] GROUP1_RESET = 16'h00F0;
  localparam logic [NUM_ACCELS-1:0] GROUP2_RESET = 16'h0F00;
  localparam logic [NUM_ACCELS-1:0] GROUP3_RESET = 16'h1000;

  localparam logic KIND_REQUEST = 1'b0;
  localparam logic KIND_DONE    = 1'b1;

  typedef enum logic [2:0] {
    ACT_STARTED   = 3'd0,
    ACT_QUEUED    = 3'd1,
    ACT_DONE      = 3'd2,
    ACT_RESTARTED = 3'd3,
    ACT_IGNORED   = 3'd4,
    ACT_REJECTED  = 3'd5
  } action_t;

  typedef struct packed {
    logic                kind;
    logic [GROUP_W-1:0]  group_id;
    logic [SLOT_W-1:0]   slot_id;
    logic [ACCEL_W-1:0]  accel_id;
  } item_t;

  typedef struct packed {
    action_t               action;
    logic [SLOT_W-1:0]     finished_slot;
    logic [ACCEL_W-1:0]    start_accel;
    logic [SLOT_W-1:0]     start_slot;
    logic [NUM_ACCELS-1:0] busy_mask;
  } result_t;

  typedef struct packed {
    logic push;
    logic pop;
  } q_ctrl_t;

  typedef struct packed {
    logic              full;
    logic              nonempty;
    logic [SLOT_W-1:0] head_slot;
  } q_status_t;

  // pointer advance with wrap at the slot count
  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p,
                                                input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] sum;
    sum = {1'b0, p} + CNT_W'(1);
    return (sum >= cap) ? '0 : sum[PTR_W-1:0];
  endfunction

endpackage

/* hdl/apd_queue.sv */
// Per-group FIFO wait queue of slot indexes.
`timescale 1ns / 1ps
module apd_queue (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [apd_pkg::CNT_W-1:0] cap,
  input  apd_pkg::q_ctrl_t          ctrl,
  input  logic [apd_pkg::SLOT_W-1:0] push_slot,
  output apd_pkg::q_status_t        status
);
  import apd_pkg::*;

  logic [SLOT_W-1:0] mem_r [QDEPTH];
  logic [PTR_W-1:0]  head_r;
  logic [PTR_W-1:0]  tail_r;
  logic [CNT_W-1:0]  count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      if (ctrl.push) begin
        head_r  <= next_ptr(head_r, cap);
        count_r <= count_r + CNT_W'(1);
      end else if (ctrl.pop) begin
        tail_r  <= next_ptr(tail_r, cap);
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem_r[head_r] <= push_slot;
    end
  end

  assign status.full      = (count_r >= cap);
  assign status.nonempty  = (count_r != '0);
  assign status.head_slot = mem_r[tail_r];

endmodule

/* hdl/apd_pool.sv */
// Accelerator busy state, slot bookkeeping and the dispatch decision.
`timescale 1ns / 1ps
module apd_pool (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          fire,
  input  apd_pkg::item_t                item,
  input  logic [apd_pkg::NUM_ACCELS-1:0] members [apd_pkg::NUM_GROUPS],
  input  apd_pkg::q_status_t            q_status [apd_pkg::NUM_GROUPS],
  output apd_pkg::q_ctrl_t              q_ctrl [apd_pkg::NUM_GROUPS],
  output logic [apd_pkg::SLOT_W-1:0]    push_slot,
  output apd_pkg::result_t              result
);
  import apd_pkg::*;

  logic [NUM_ACCELS-1:0] busy_r, busy_nxt;
  logic [SLOT_W-1:0]     serving_r [NUM_ACCELS];

  logic [NUM_ACCELS-1:0] owned [NUM_GROUPS];
  logic [NUM_ACCELS-1:0] idle;
  logic [ACCEL_W-1:0]    pick;
  logic [GROUP_W-1:0]    owner;
  logic                  owner_found;
  logic                  srv_we;
  logic [ACCEL_W-1:0]    srv_addr;
  logic [SLOT_W-1:0]     srv_data;
  logic                  do_push, do_pop;

  // lower groups win shared members
  always_comb begin
    logic [NUM_ACCELS-1:0] taken;
    taken = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      owned[g] = members[g] & ~taken;
      taken    = taken | members[g];
    end
  end

  assign idle = owned[item.group_id] & ~busy_r;

  always_comb begin
    pick = '0;
    for (int i = NUM_ACCELS - 1; i >= 0; i--) begin
      if (idle[i]) pick = ACCEL_W'(i);
    end
  end

  always_comb begin
    owner       = '0;
    owner_found = 1'b0;
    for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
      if (owned[g][item.accel_id]) begin
        owner       = GROUP_W'(g);
        owner_found = 1'b1;
      end
    end
  end

  always_comb begin
    busy_nxt             = busy_r;
    srv_we               = 1'b0;
    srv_addr             = item.accel_id;
    srv_data             = item.slot_id;
    do_push              = 1'b0;
    do_pop               = 1'b0;
    result.action        = ACT_IGNORED;
    result.finished_slot = '0;
    result.start_accel   = '0;
    result.start_slot    = '0;
    if (item.kind == KIND_REQUEST) begin
      if (idle != '0) begin
        busy_nxt[pick]     = 1'b1;
        srv_we             = 1'b1;
        srv_addr           = pick;
        result.action      = ACT_STARTED;
        result.start_accel = pick;
        result.start_slot  = item.slot_id;
      end else if (q_status[item.group_id].full) begin
        result.action = ACT_REJECTED;
      end else begin
        do_push       = 1'b1;
        result.action = ACT_QUEUED;
      end
    end else if (busy_r[item.accel_id]) begin
      result.finished_slot     = serving_r[item.accel_id];
      busy_nxt[item.accel_id]  = 1'b0;
      if (owner_found && q_status[owner].nonempty) begin
        do_pop                  = 1'b1;
        busy_nxt[item.accel_id] = 1'b1;
        srv_we                  = 1'b1;
        srv_data                = q_status[owner].head_slot;
        result.action           = ACT_RESTARTED;
        result.start_accel      = item.accel_id;
        result.start_slot       = q_status[owner].head_slot;
      end else begin
        result.action = ACT_DONE;
      end
    end
    result.busy_mask = busy_nxt;
  end

  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      q_ctrl[g].push = fire && do_push && (item.group_id == GROUP_W'(g));
      q_ctrl[g].pop  = fire && do_pop && (owner == GROUP_W'(g));
    end
  end

  assign push_slot = item.slot_id;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= '0;
    end else if (fire) begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && srv_we) begin
      serving_r[srv_addr] <= srv_data;
    end
  end

endmodule

/* hdl/accelerator_pool_dispatcher.sv */
// Top level: stream ports, config registers, input/result registers, queues and pool.
//
// Usage:
//   Input words carry either a slot request (in_tuser = 0: group and slot) or a
//   done report (in_tuser = 1: accelerator index). Each input word yields exactly
//   one result word on the out_ channel: the action code, the finished slot, the
//   started accelerator and slot, and the busy mask after the word.
//   The word is held in the input register, then the dispatch decision and state
//   update land in the result register once it is free, raising out_tvalid.
//   Throughput is one word per cycle while out_tready stays high; the decision is
//   a 16-bit priority pick plus one queue pointer step, all in that single stage.
//   When out_tready is low the result register holds its word and the input
//   register can still take one more word; after that in_tready drops until
//   the result register drains.
//   Reset (rst_n low, synchronous) clears busy state, queue pointers and counts,
//   both stage valids, and loads default config: 16 slots and group masks
//   0x000F, 0x00F0, 0x0F00, 0x1000. Config writes should be taken only while
//   the block is idle; the user ensures this, the block does not enforce it.
`timescale 1ns / 1ps
module accelerator_pool_dispatcher (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [apd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [apd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [1:0] group_id, [5:2] slot_id, [9:6] accel_id, [15:10] zero
  input  logic [apd_pkg::IN_DATA_W-1:0]      in_tdata,
  // [0] kind
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [2:0] action, [6:3] finished_slot, [10:7] start_accel, [14:11] start_slot,
  // [30:15] busy_mask, [31] zero
  output logic [apd_pkg::OUT_DATA_W-1:0]     out_tdata
);
  import apd_pkg::*;

  logic [CNT_W-1:0]      slots_r;
  logic [NUM_ACCELS-1:0] members_r [NUM_GROUPS];
  logic [CNT_W-1:0]      cap;

  logic                  in_valid_r;
  item_t                 item_r;
  logic                  out_valid_r;
  result_t               res_r;
  logic [NUM_ACCELS-1:0] last_busy_r;
  logic                  advance;

  q_ctrl_t               q_ctrl   [NUM_GROUPS];
  q_status_t             q_status [NUM_GROUPS];
  logic [SLOT_W-1:0]     push_slot;
  result_t               result;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_r      <= SLOTS_RESET;
      members_r[0] <= GROUP0_RESET;
      members_r[1] <= GROUP1_RESET;
      members_r[2] <= GROUP2_RESET;
      members_r[3] <= GROUP3_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SLOTS_IN_USE: slots_r      <= cfg_wdata[CNT_W-1:0];
        CFG_GROUP0:       members_r[0] <= cfg_wdata[NUM_ACCELS-1:0];
        CFG_GROUP1:       members_r[1] <= cfg_wdata[NUM_ACCELS-1:0];
        CFG_GROUP2:       members_r[2] <= cfg_wdata[NUM_ACCELS-1:0];
        CFG_GROUP3:       members_r[3] <= cfg_wdata[NUM_ACCELS-1:0];
        default: ;
      endcase
    end
  end

  // queue capacity: zero acts as one, saturate at queue depth
  always_comb begin
    if (slots_r == '0) begin
      cap = CNT_W'(1);
    end else if (slots_r > CNT_W'(QDEPTH)) begin
      cap = CNT_W'(QDEPTH);
    end else begin
      cap = slots_r;
    end
  end

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.kind     <= in_tuser;
      item_r.group_id <= in_tdata[1:0];
      item_r.slot_id  <= in_tdata[5:2];
      item_r.accel_id <= in_tdata[9:6];
    end
  end

  for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_queue
    apd_queue u_queue (
      .clk       (clk),
      .rst_n     (rst_n),
      .cap       (cap),
      .ctrl      (q_ctrl[g]),
      .push_slot (push_slot),
      .status    (q_status[g])
    );
  end

  apd_pool u_pool (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (advance),
    .item      (item_r),
    .members   (members_r),
    .q_status  (q_status),
    .q_ctrl    (q_ctrl),
    .push_slot (push_slot),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      last_busy_r <= '0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
      last_busy_r <= result.busy_mask;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, res_r.busy_mask, res_r.start_slot, res_r.start_accel,
                       res_r.finished_slot, res_r.action};

  // a fresh start always shows its accelerator as busy
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (res_r.action == ACT_STARTED) |-> res_r.busy_mask[res_r.start_accel])
    else $error("started accelerator not marked busy");

  // words that neither start nor release leave the busy mask untouched
  assert property (@(posedge clk) disable iff (!rst_n)
    advance && (result.action == ACT_QUEUED || result.action == ACT_REJECTED ||
                result.action == ACT_IGNORED) |-> result.busy_mask == last_busy_r)
    else $error("busy mask changed on a non-dispatch word");

  // a restart reuses the reporting accelerator and keeps it busy
  assert property (@(posedge clk) disable iff (!rst_n)
    advance && (result.action == ACT_RESTARTED) |->
      (result.start_accel == item_r.accel_id) && result.busy_mask[item_r.accel_id])
    else $error("restart on wrong accelerator");

  // nothing comes out the cycle after reset
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule
